// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the project.
// Depends on nothing; the caller supplies clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another one in the same cycle
`define ASSERT_SAME_CYCLE(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("%m: same-cycle property violated");

// Check that a condition implies another one in the following cycle
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("%m: next-cycle property violated");

`endif

// ===== src/tawp_pkg.sv =====
// Shared types and constants of the task admission controller.
// Depends on nothing; used by the interfaces, the cell, the top level and the checker.
package tawp_pkg;

    // Default sizes of the stores and ids
    localparam int ACTIVE_DEPTH_DEF = 16;
    localparam int WAIT_DEPTH_DEF   = 16;
    localparam int ID_WIDTH_DEF     = 8;

    // Fixed field widths
    localparam int CFG_W  = 5;
    localparam int MODE_W = 2;
    localparam int PRI_W  = 2;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RETIRE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PROMOTE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

    // Load priorities
    localparam logic [PRI_W-1:0] PRI_CANCEL = 2'd0;
    localparam logic [PRI_W-1:0] PRI_WAIT   = 2'd1;
    localparam logic [PRI_W-1:0] PRI_LOAD   = 2'd2;
    localparam logic [PRI_W-1:0] PRI_ALWAYS = 2'd3;

    // Configuration register indexes
    localparam logic CFG_ACTIVE_LIMIT  = 1'b0;
    localparam logic CFG_WAITING_LIMIT = 1'b1;

    // Match rule applied by every cell of the active chain
    typedef enum logic [1:0] {
        MATCH_NONE,
        MATCH_LOWER,
        MATCH_DIFF,
        MATCH_SAME
    } match_t;

    // Control broadcast from the sequencer to all cells
    typedef struct packed {
        logic             shift;
        logic             write;
        match_t           kind;
        logic [PRI_W-1:0] new_pri;
    } cell_ctl_t;

endpackage

// ===== src/tawp_req_if.sv =====
// Request channel of the task admission controller.
// Depends on tawp_pkg for field widths.
interface tawp_req_if #(
    parameter int ID_WIDTH = tawp_pkg::ID_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic [tawp_pkg::MODE_W-1:0]  mode;
    logic [ID_WIDTH-1:0]          task_id;
    logic [tawp_pkg::PRI_W-1:0]   priority_req;

    modport source (output valid, output mode, output task_id, output priority_req,
                    input ready);
    modport sink   (input valid, input mode, input task_id, input priority_req,
                    output ready);
endinterface

// ===== src/tawp_res_if.sv =====
// Result channel of the task admission controller.
// Depends on tawp_pkg for the default id width.
interface tawp_res_if #(
    parameter int ID_WIDTH = tawp_pkg::ID_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic                started;
    logic                finished;
    logic                evicted_valid;
    logic [ID_WIDTH-1:0] evicted_id;
    logic                promoted_valid;
    logic [ID_WIDTH-1:0] promoted_id;

    modport source (output valid, output started, output finished, output evicted_valid,
                    output evicted_id, output promoted_valid, output promoted_id,
                    input ready);
    modport sink   (input valid, input started, input finished, input evicted_valid,
                    input evicted_id, input promoted_valid, input promoted_id,
                    output ready);
endinterface

// ===== src/tawp_cell.sv =====
// One slot of the ordered active list: stored id and priority.
// Depends on tawp_pkg for the broadcast control struct.
module tawp_cell #(
    parameter int IDX      = 0,
    parameter int ID_WIDTH = tawp_pkg::ID_WIDTH_DEF,
    parameter int CNT_W    = 5
) (
    input  logic                       clk,
    input  tawp_pkg::cell_ctl_t        ctl,
    input  logic [CNT_W-1:0]           count,
    input  logic [ID_WIDTH-1:0]        key_id,
    input  logic [ID_WIDTH-1:0]        new_id,
    input  logic                       found_in,
    input  logic [ID_WIDTH-1:0]        sel_in,
    input  logic [ID_WIDTH-1:0]        younger_id,
    input  logic [tawp_pkg::PRI_W-1:0] younger_pri,
    output logic                       found_out,
    output logic [ID_WIDTH-1:0]        sel_out,
    output logic [ID_WIDTH-1:0]        pass_id,
    output logic [tawp_pkg::PRI_W-1:0] pass_pri
);

    logic [ID_WIDTH-1:0]        id_reg;
    logic [tawp_pkg::PRI_W-1:0] pri_reg;
    logic                       occ;
    logic                       hit;

    assign occ = (CNT_W'(IDX) < count);

    // Evaluate the match rule on an occupied slot
    always_comb
    begin
        case (ctl.kind)
            tawp_pkg::MATCH_LOWER: hit = occ && (pri_reg < tawp_pkg::PRI_LOAD);
            tawp_pkg::MATCH_DIFF:  hit = occ && (id_reg != key_id);
            tawp_pkg::MATCH_SAME:  hit = occ && (id_reg == key_id);
            default:               hit = 1'b0;
        endcase
    end

    // Carry the first hit toward the young end
    assign found_out = found_in | hit;
    assign sel_out   = (!found_in && hit) ? id_reg : sel_in;

    // Offer own entry to the older neighbor, or the new entry past the last one
    assign pass_id  = occ ? id_reg  : new_id;
    assign pass_pri = occ ? pri_reg : ctl.new_pri;

    // Shift down at and after the first hit, or take the appended entry
    always_ff @(posedge clk)
    begin
        if (ctl.shift && found_out)
        begin
            id_reg  <= younger_id;
            pri_reg <= younger_pri;
        end
        else if (ctl.write && (CNT_W'(IDX) == count))
        begin
            id_reg  <= new_id;
            pri_reg <= ctl.new_pri;
        end
    end

endmodule

// ===== src/tawp_wait_fifo.sv =====
// Waiting FIFO of task ids with a registered head read.
// Depends on nothing but its parameters.
module tawp_wait_fifo #(
    parameter int WAIT_DEPTH = 16,
    parameter int ID_WIDTH   = 8,
    parameter int CNT_W      = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [ID_WIDTH-1:0] push_id,
    input  logic                pop,
    input  logic                clear,
    output logic [CNT_W-1:0]    count,
    output logic [ID_WIDTH-1:0] head_id
);

    localparam int PTR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(WAIT_DEPTH - 1);

    logic [ID_WIDTH-1:0] mem [WAIT_DEPTH];
    logic [PTR_W-1:0]    head_reg;
    logic [PTR_W-1:0]    tail_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [ID_WIDTH-1:0] head_id_reg;

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (clear)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (push)
        begin
            tail_reg  <= (tail_reg == LAST) ? '0 : tail_reg + PTR_W'(1);
            count_reg <= count_reg + CNT_W'(1);
        end
        else if (pop)
        begin
            head_reg  <= (head_reg == LAST) ? '0 : head_reg + PTR_W'(1);
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Write at the tail, read the head into a register
    always_ff @(posedge clk)
    begin
        if (push && !clear)
        begin
            mem[tail_reg] <= push_id;
        end
        head_id_reg <= mem[head_reg];
    end

    assign count   = count_reg;
    assign head_id = head_id_reg;

endmodule

// ===== src/task_admission_with_preemption.sv =====
// Task admission controller: ordered active list as a chain of cells plus a waiting FIFO.
// A request is captured in S_IDLE, executed in S_EXEC and its outcome registered; retire
// stays in S_EXEC until no match is left. A new request is taken only in S_IDLE; retire
// removes one matching entry per cycle through the cell chain unless a stalled result holds it.
// Reset: counts, FIFO pointers and limits clear at once; stored ids are undefined until
// written. The result register lets a new request in while a result waits.
module task_admission_with_preemption #(
    parameter int ACTIVE_DEPTH = tawp_pkg::ACTIVE_DEPTH_DEF,
    parameter int WAIT_DEPTH   = tawp_pkg::WAIT_DEPTH_DEF,
    parameter int ID_WIDTH     = tawp_pkg::ID_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    tawp_req_if.sink                   req,
    tawp_res_if.source                 res,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [tawp_pkg::CFG_W-1:0] cfg_data
);

    localparam int ACNT_W = $clog2(ACTIVE_DEPTH + 1);
    localparam int WCNT_W = $clog2(WAIT_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                       state_reg;
    logic [tawp_pkg::MODE_W-1:0]  mode_reg;
    logic [ID_WIDTH-1:0]          tid_reg;
    logic [tawp_pkg::PRI_W-1:0]   pri_reg;
    logic [ACNT_W-1:0]            count_reg;
    logic [ACNT_W-1:0]            count_next;
    logic [tawp_pkg::CFG_W-1:0]   alim_reg;
    logic [tawp_pkg::CFG_W-1:0]   wlim_reg;

    logic                         res_valid_reg;
    logic                         started_reg;
    logic                         finished_reg;
    logic                         ev_valid_reg;
    logic [ID_WIDTH-1:0]          ev_id_reg;
    logic                         pr_valid_reg;
    logic [ID_WIDTH-1:0]          pr_id_reg;

    logic                         advance;
    logic                         exec;
    logic                         done;
    logic                         started;
    logic                         finished;
    logic                         ev_valid;
    logic [ID_WIDTH-1:0]          ev_id;
    logic                         pr_valid;
    logic [ID_WIDTH-1:0]          pr_id;

    logic [ACNT_W-1:0]            amax;
    logic [WCNT_W-1:0]            wmax;
    tawp_pkg::cell_ctl_t          ctl;
    logic [ID_WIDTH-1:0]          new_id;

    logic                         fifo_push;
    logic                         fifo_pop;
    logic                         fifo_clear;
    logic [WCNT_W-1:0]            wcount;
    logic [ID_WIDTH-1:0]          head_id;

    logic                         found_c    [ACTIVE_DEPTH+1];
    logic [ID_WIDTH-1:0]          sel_c      [ACTIVE_DEPTH+1];
    logic [ID_WIDTH-1:0]          pass_id_c  [ACTIVE_DEPTH+1];
    logic [tawp_pkg::PRI_W-1:0]   pass_pri_c [ACTIVE_DEPTH+1];

    // Hold the limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alim_reg <= '0;
            wlim_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == tawp_pkg::CFG_ACTIVE_LIMIT)
            begin
                alim_reg <= cfg_data;
            end
            else
            begin
                wlim_reg <= cfg_data;
            end
        end
    end

    // Map a zero or oversized limit to the store depth
    always_comb
    begin
        if (alim_reg == '0 || int'(alim_reg) > ACTIVE_DEPTH)
        begin
            amax = ACNT_W'(ACTIVE_DEPTH);
        end
        else
        begin
            amax = ACNT_W'(alim_reg);
        end
        if (wlim_reg == '0 || int'(wlim_reg) > WAIT_DEPTH)
        begin
            wmax = WCNT_W'(WAIT_DEPTH);
        end
        else
        begin
            wmax = WCNT_W'(wlim_reg);
        end
    end

    assign advance = !res_valid_reg || res.ready;
    assign exec    = (state_reg == S_EXEC) && advance;

    // Decide the step for the captured request
    always_comb
    begin
        ctl         = '{shift: 1'b0, write: 1'b0, kind: tawp_pkg::MATCH_NONE,
                        new_pri: pri_reg};
        new_id      = tid_reg;
        count_next  = count_reg;
        fifo_push   = 1'b0;
        fifo_pop    = 1'b0;
        fifo_clear  = 1'b0;
        done        = 1'b1;
        started     = 1'b0;
        finished    = 1'b1;
        ev_valid    = 1'b0;
        ev_id       = '0;
        pr_valid    = 1'b0;
        pr_id       = '0;
        if (exec)
        begin
            case (mode_reg)
                tawp_pkg::MODE_LOAD:
                begin
                    if (count_reg < amax)
                    begin
                        ctl.write  = 1'b1;
                        count_next = count_reg + ACNT_W'(1);
                        started    = 1'b1;
                    end
                    else if (pri_reg == tawp_pkg::PRI_WAIT)
                    begin
                        if (wcount < wmax)
                        begin
                            fifo_push = 1'b1;
                            finished  = 1'b0;
                        end
                    end
                    else if (pri_reg == tawp_pkg::PRI_LOAD || pri_reg == tawp_pkg::PRI_ALWAYS)
                    begin
                        ctl.shift = 1'b1;
                        ctl.kind  = (pri_reg == tawp_pkg::PRI_LOAD) ? tawp_pkg::MATCH_LOWER
                                                                    : tawp_pkg::MATCH_DIFF;
                        if (found_c[ACTIVE_DEPTH])
                        begin
                            started  = 1'b1;
                            ev_valid = 1'b1;
                            ev_id    = sel_c[ACTIVE_DEPTH];
                        end
                    end
                end
                tawp_pkg::MODE_RETIRE:
                begin
                    // Drop the oldest match; repeat until none is left
                    ctl.shift = 1'b1;
                    ctl.kind  = tawp_pkg::MATCH_SAME;
                    if (found_c[ACTIVE_DEPTH])
                    begin
                        count_next = count_reg - ACNT_W'(1);
                        done       = 1'b0;
                    end
                end
                tawp_pkg::MODE_PROMOTE:
                begin
                    new_id = head_id;
                    if (wcount != '0 && count_reg < amax)
                    begin
                        ctl.write   = 1'b1;
                        ctl.new_pri = tawp_pkg::PRI_WAIT;
                        fifo_pop    = 1'b1;
                        count_next  = count_reg + ACNT_W'(1);
                        pr_valid    = 1'b1;
                        pr_id       = head_id;
                    end
                end
                tawp_pkg::MODE_CLEAR:
                begin
                    count_next = '0;
                    fifo_clear = 1'b1;
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end
    end

    // Hold sequencer state, captured request and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= '0;
            tid_reg       <= '0;
            pri_reg       <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            finished_reg  <= 1'b0;
            ev_valid_reg  <= 1'b0;
            ev_id_reg     <= '0;
            pr_valid_reg  <= 1'b0;
            pr_id_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        mode_reg  <= req.mode;
                        tid_reg   <= req.task_id;
                        pri_reg   <= req.priority_req;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (advance)
                    begin
                        count_reg <= count_next;
                        if (done)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (exec && done)
            begin
                res_valid_reg <= 1'b1;
                started_reg   <= started;
                finished_reg  <= finished;
                ev_valid_reg  <= ev_valid;
                ev_id_reg     <= ev_id;
                pr_valid_reg  <= pr_valid;
                pr_id_reg     <= pr_id;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign res.valid          = res_valid_reg;
    assign res.started        = started_reg;
    assign res.finished       = finished_reg;
    assign res.evicted_valid  = ev_valid_reg;
    assign res.evicted_id     = ev_id_reg;
    assign res.promoted_valid = pr_valid_reg;
    assign res.promoted_id    = pr_id_reg;

    // Feed the chain ends
    assign found_c[0]               = 1'b0;
    assign sel_c[0]                 = '0;
    assign pass_id_c[ACTIVE_DEPTH]  = new_id;
    assign pass_pri_c[ACTIVE_DEPTH] = ctl.new_pri;

    // Build the active list, oldest entry in cell zero
    for (genvar j = 0; j < ACTIVE_DEPTH; j++)
    begin : g_cell
        tawp_cell #(
            .IDX      (j),
            .ID_WIDTH (ID_WIDTH),
            .CNT_W    (ACNT_W)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .count       (count_reg),
            .key_id      (tid_reg),
            .new_id      (new_id),
            .found_in    (found_c[j]),
            .sel_in      (sel_c[j]),
            .younger_id  (pass_id_c[j+1]),
            .younger_pri (pass_pri_c[j+1]),
            .found_out   (found_c[j+1]),
            .sel_out     (sel_c[j+1]),
            .pass_id     (pass_id_c[j]),
            .pass_pri    (pass_pri_c[j])
        );
    end

    tawp_wait_fifo #(
        .WAIT_DEPTH (WAIT_DEPTH),
        .ID_WIDTH   (ID_WIDTH),
        .CNT_W      (WCNT_W)
    ) u_wait_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fifo_push),
        .push_id (tid_reg),
        .pop     (fifo_pop),
        .clear   (fifo_clear),
        .count   (wcount),
        .head_id (head_id)
    );

endmodule

// ===== src/tawp_checker.sv =====
// Port-level checks of the task admission controller, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tawp_checker #(
    parameter int ID_WIDTH = tawp_pkg::ID_WIDTH_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                res_valid,
    input logic                res_ready,
    input logic                started,
    input logic                evicted_valid,
    input logic                promoted_valid,
    input logic [ID_WIDTH-1:0] evicted_id
);

    // Keep a stalled result on the channel
    `ASSERT_NEXT_CYCLE(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid)

    // Take no new request in the cycle after a transaction is accepted
    `ASSERT_NEXT_CYCLE(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready)

    // Report an eviction only together with a start
    `ASSERT_SAME_CYCLE(a_evict_starts, clk, rst_n, res_valid && evicted_valid, started)

    // Keep promotion apart from load outcomes, and zero the id of no eviction
    `ASSERT_SAME_CYCLE(a_promote_alone, clk, rst_n, res_valid && promoted_valid,
                       !started && !evicted_valid)
    `ASSERT_SAME_CYCLE(a_evict_id_zero, clk, rst_n, res_valid && !evicted_valid,
                       evicted_id == '0)

endmodule

bind task_admission_with_preemption tawp_checker #(
    .ID_WIDTH (ID_WIDTH)
) u_tawp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .started        (res.started),
    .evicted_valid  (res.evicted_valid),
    .promoted_valid (res.promoted_valid),
    .evicted_id     (res.evicted_id)
);

// ===== tb/tb_task_admission_with_preemption.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for task_admission_with_preemption: an in-bench model of the active list
// and waiting FIFO predicts each result; depends on tawp_pkg and the tawp_req_if/tawp_res_if files.
module tb_task_admission_with_preemption;

    localparam int ACT_DEPTH   = tawp_pkg::ACTIVE_DEPTH_DEF;
    localparam int PARK_DEPTH  = tawp_pkg::WAIT_DEPTH_DEF;
    localparam int ID_W        = tawp_pkg::ID_WIDTH_DEF;
    localparam int PRI_BITS    = tawp_pkg::PRI_W;
    localparam int CFG_BITS    = tawp_pkg::CFG_W;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic            started;
        logic            finished;
        logic            evicted_valid;
        logic [ID_W-1:0] evicted_id;
        logic            promoted_valid;
        logic [ID_W-1:0] promoted_id;
    } outcome_t;

    typedef struct {
        logic [ID_W-1:0]              id;
        logic [tawp_pkg::PRI_W-1:0]   pri;
    } slot_t;

    // Admission model plus the queue of outcomes still owed by the block
    class admission_tracker;
        slot_t           live[$];
        logic [ID_W-1:0] parked[$];
        int unsigned     live_cap_reg;
        int unsigned     park_cap_reg;
        outcome_t        owed[$];
        int              mismatches;

        function new();
            live_cap_reg = 0;
            park_cap_reg = 0;
            mismatches   = 0;
        endfunction

        function void set_limits(int unsigned act_lim, int unsigned park_lim);
            live_cap_reg = act_lim;
            park_cap_reg = park_lim;
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        // Zero or oversized limit means the full store
        function int unsigned capacity(int unsigned lim, int unsigned depth);
            return (lim == 0 || lim > depth) ? depth : lim;
        endfunction

        function void push_live(logic [ID_W-1:0] id, logic [tawp_pkg::PRI_W-1:0] pri);
            slot_t s;
            s.id  = id;
            s.pri = pri;
            if (live.size() < ACT_DEPTH)
                live.insert(live.size(), s);
        endfunction

        // Advance the model by one accepted transaction and queue its outcome
        function void note_request(logic [tawp_pkg::MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                   logic [tawp_pkg::PRI_W-1:0] pri);
            outcome_t    o;
            int unsigned amax;
            int unsigned wmax;
            int          i;
            bit          hit;
            o.started        = 1'b0;
            o.finished       = 1'b1;
            o.evicted_valid  = 1'b0;
            o.evicted_id     = '0;
            o.promoted_valid = 1'b0;
            o.promoted_id    = '0;
            amax = capacity(live_cap_reg, ACT_DEPTH);
            wmax = capacity(park_cap_reg, PARK_DEPTH);
            case (mode)
                tawp_pkg::MODE_LOAD:
                begin
                    if (live.size() < amax)
                    begin
                        push_live(id, pri);
                        o.started = 1'b1;
                    end
                    else if (pri == tawp_pkg::PRI_WAIT)
                    begin
                        if (parked.size() < wmax)
                        begin
                            parked.insert(parked.size(), id);
                            o.finished = 1'b0;
                        end
                    end
                    else if (pri == tawp_pkg::PRI_LOAD || pri == tawp_pkg::PRI_ALWAYS)
                    begin
                        // Evict the oldest entry that this priority may displace
                        for (i = 0; i < live.size() && !o.evicted_valid; i++)
                        begin
                            hit = (pri == tawp_pkg::PRI_LOAD) ? (live[i].pri < pri)
                                                              : (live[i].id != id);
                            if (hit)
                            begin
                                o.evicted_valid = 1'b1;
                                o.evicted_id    = live[i].id;
                                live.delete(i);
                                push_live(id, pri);
                                o.started = 1'b1;
                            end
                        end
                    end
                end
                tawp_pkg::MODE_RETIRE:
                begin
                    i = 0;
                    while (i < live.size())
                    begin
                        if (live[i].id == id)
                            live.delete(i);
                        else
                            i++;
                    end
                end
                tawp_pkg::MODE_PROMOTE:
                begin
                    if (parked.size() > 0 && live.size() < amax)
                    begin
                        o.promoted_id    = parked.pop_front();
                        o.promoted_valid = 1'b1;
                        push_live(o.promoted_id, tawp_pkg::PRI_WAIT);
                    end
                end
                default:
                begin
                    live.delete();
                    parked.delete();
                end
            endcase
            owed.insert(owed.size(), o);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
            if (seen !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                mismatches++;
            end
        endfunction

        // Compare a received outcome with the oldest one owed
        function void check_outcome(outcome_t got);
            outcome_t want;
            if (owed.size() == 0)
            begin
                $error("result transaction with no request outstanding");
                mismatches++;
                return;
            end
            want = owed.pop_front();
            compare_field("started", 16'(want.started), 16'(got.started));
            compare_field("finished", 16'(want.finished), 16'(got.finished));
            compare_field("evicted_valid", 16'(want.evicted_valid), 16'(got.evicted_valid));
            compare_field("evicted_id", 16'(want.evicted_id), 16'(got.evicted_id));
            compare_field("promoted_valid", 16'(want.promoted_valid),
                          16'(got.promoted_valid));
            compare_field("promoted_id", 16'(want.promoted_id), 16'(got.promoted_id));
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic                        cfg_index;
    logic [tawp_pkg::CFG_W-1:0]  cfg_data;
    bit                          tx_steady;
    bit                          rx_steady;
    int                          cycle_count;
    admission_tracker            board;

    tawp_req_if #(.ID_WIDTH(ID_W)) req_ch ();
    tawp_res_if #(.ID_WIDTH(ID_W)) res_ch ();

    task_admission_with_preemption #(
        .ACTIVE_DEPTH (ACT_DEPTH),
        .WAIT_DEPTH   (PARK_DEPTH),
        .ID_WIDTH     (ID_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int draw_gap(bit steady);
        return steady ? 0 : $urandom_range(0, 11);
    endfunction

    // Present one request and hold it until the block takes it
    task automatic send_request(input logic [tawp_pkg::MODE_W-1:0] mode,
                                input logic [ID_W-1:0] id,
                                input logic [tawp_pkg::PRI_W-1:0] pri);
        int gap;
        gap = draw_gap(tx_steady);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= mode;
        req_ch.task_id      <= id;
        req_ch.priority_req <= pri;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_request(mode, id, pri);
    endtask

    // Drop valid and hold until every owed result has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both limit registers on consecutive edges
    task automatic write_limits(input logic [tawp_pkg::CFG_W-1:0] act_lim,
                                input logic [tawp_pkg::CFG_W-1:0] park_lim);
        cfg_we    <= 1'b1;
        cfg_index <= tawp_pkg::CFG_ACTIVE_LIMIT;
        cfg_data  <= act_lim;
        @(posedge clk);
        cfg_index <= tawp_pkg::CFG_WAITING_LIMIT;
        cfg_data  <= park_lim;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_limits(32'(act_lim), 32'(park_lim));
    endtask

    // Random request: a small id pool makes retires and same-id loads collide
    task automatic send_random();
        int                          r;
        logic [tawp_pkg::MODE_W-1:0] mode;
        logic [ID_W-1:0]             id;
        r = $urandom_range(0, 99);
        if (r < 55)
            mode = tawp_pkg::MODE_LOAD;
        else if (r < 75)
            mode = tawp_pkg::MODE_RETIRE;
        else if (r < 97)
            mode = tawp_pkg::MODE_PROMOTE;
        else
            mode = tawp_pkg::MODE_CLEAR;
        if ($urandom_range(0, 3) == 0)
            id = ID_W'($urandom());
        else
            id = ID_W'($urandom_range(0, 7));
        send_request(mode, id, PRI_BITS'($urandom_range(0, 3)));
    endtask

    // Result side: stall at random, check every accepted transaction
    initial
    begin : result_sink
        int       gap;
        int       taken;
        outcome_t got;
        taken = 0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken % 64 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
            gap = draw_gap(rx_steady);
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
            got.started        = res_ch.started;
            got.finished       = res_ch.finished;
            got.evicted_valid  = res_ch.evicted_valid;
            got.evicted_id     = res_ch.evicted_id;
            got.promoted_valid = res_ch.promoted_valid;
            got.promoted_id    = res_ch.promoted_id;
            board.check_outcome(got);
            taken++;
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int n;
        logic [tawp_pkg::CFG_W-1:0] act_tab [4];
        logic [tawp_pkg::CFG_W-1:0] park_tab [4];
        act_tab  = '{5'd16, 5'd1, 5'd0, 5'd31};
        park_tab = '{5'd0, 5'd16, 5'd1, 5'd17};
        board = new();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.mode         <= tawp_pkg::MODE_LOAD;
        req_ch.task_id      <= '0;
        req_ch.priority_req <= tawp_pkg::PRI_CANCEL;
        cfg_we              <= 1'b0;
        cfg_index           <= tawp_pkg::CFG_ACTIVE_LIMIT;
        cfg_data            <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tiny stores so every admission path shows up quickly
        write_limits(5'd2, 5'd2);
        send_request(tawp_pkg::MODE_CLEAR, 8'hFF, tawp_pkg::PRI_ALWAYS);
        send_request(tawp_pkg::MODE_LOAD, 8'h00, tawp_pkg::PRI_CANCEL);
        send_request(tawp_pkg::MODE_LOAD, 8'hFF, tawp_pkg::PRI_WAIT);
        send_request(tawp_pkg::MODE_LOAD, 8'h11, tawp_pkg::PRI_CANCEL); // full: cancel refused
        send_request(tawp_pkg::MODE_LOAD, 8'h12, tawp_pkg::PRI_WAIT);   // queued
        send_request(tawp_pkg::MODE_LOAD, 8'h13, tawp_pkg::PRI_WAIT);   // queued
        send_request(tawp_pkg::MODE_LOAD, 8'h14, tawp_pkg::PRI_WAIT);   // FIFO full: refused
        send_request(tawp_pkg::MODE_LOAD, 8'h20, tawp_pkg::PRI_LOAD);   // evicts cancel entry
        send_request(tawp_pkg::MODE_LOAD, 8'h21, tawp_pkg::PRI_LOAD);   // evicts wait entry
        send_request(tawp_pkg::MODE_LOAD, 8'h22, tawp_pkg::PRI_LOAD);   // nothing lower
        send_request(tawp_pkg::MODE_LOAD, 8'h20, tawp_pkg::PRI_ALWAYS); // evicts the other id
        send_request(tawp_pkg::MODE_LOAD, 8'h20, tawp_pkg::PRI_ALWAYS); // all ids equal
        send_request(tawp_pkg::MODE_PROMOTE, 8'h00, tawp_pkg::PRI_CANCEL); // active full
        send_request(tawp_pkg::MODE_RETIRE, 8'h20, tawp_pkg::PRI_CANCEL);  // removes both copies
        send_request(tawp_pkg::MODE_RETIRE, 8'h55, tawp_pkg::PRI_LOAD);    // no match
        send_request(tawp_pkg::MODE_PROMOTE, 8'hFF, tawp_pkg::PRI_ALWAYS);
        send_request(tawp_pkg::MODE_PROMOTE, 8'h00, tawp_pkg::PRI_WAIT);
        send_request(tawp_pkg::MODE_PROMOTE, 8'h00, tawp_pkg::PRI_WAIT);   // FIFO empty
        send_request(tawp_pkg::MODE_LOAD, 8'hAA, tawp_pkg::PRI_ALWAYS);
        send_request(tawp_pkg::MODE_LOAD, 8'h55, tawp_pkg::PRI_ALWAYS);
        send_request(tawp_pkg::MODE_CLEAR, 8'h00, tawp_pkg::PRI_CANCEL);
        drain_results();

        // Random phases, each under its own pair of limits
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 4)
                write_limits(act_tab[phase], park_tab[phase]);
            else
                write_limits(CFG_BITS'($urandom_range(0, 16)),
                             CFG_BITS'($urandom_range(0, 16)));
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 50 == 0)
                    tx_steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 299) == 0)
                    drain_results();
                send_random();
            end
            drain_results();
        end

        repeat (40) @(posedge clk);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
